// ===== hdl/dss_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dss_pkg
// Shared types and constants for two stacks that share one word store.
// ----------------------------------------------------------------------------
package dss_pkg;

  // word width of the store and of the data fields
  localparam int unsigned WordW = 32;

  // default number of entries in the shared store
  localparam int unsigned DefDepth = 16;

  // word returned by a pop or peek on an empty stack
  localparam logic [WordW-1:0] IntMin = {1'b1, {(WordW-1){1'b0}}};

  // operation codes; the fourth code is unused and leaves both stacks unchanged
  typedef enum logic [1:0] {
    CMD_PUSH = 2'd0,
    CMD_POP  = 2'd1,
    CMD_PEEK = 2'd2
  } cmd_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_e;

endpackage
`default_nettype wire

// ===== hdl/dss_store.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dss_store
// Single-port synchronous word store: one write or one read per cycle,
// read data registered.
// ----------------------------------------------------------------------------
module dss_store #(
  parameter int unsigned Depth = dss_pkg::DefDepth,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic                    clk_i,
  input  wire logic                    we_i,
  input  wire logic                    re_i,
  input  wire logic [AddrW-1:0]        addr_i,
  input  wire logic [dss_pkg::WordW-1:0] wdata_i,
  output logic      [dss_pkg::WordW-1:0] rdata_o
);

  logic [dss_pkg::WordW-1:0] mem_q [Depth];
  logic [dss_pkg::WordW-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== hdl/dual_stack_shared_array.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dual_stack_shared_array
// The result beat is offered in the cycle after the input beat; the store read issued
//   at the accepting edge lands in the store's output register.
// Throughput: one item per cycle while the result side takes each beat;
//   the single store port and the one result register set this figure.
// Reset: both stack counts clear to zero and no result is pending; the
//   store contents are undefined until written.
// ----------------------------------------------------------------------------
module dual_stack_shared_array #(
  parameter int unsigned DEPTH = dss_pkg::DefDepth
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  // input channel
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic [1:0]                cmd_i,
  input  wire logic                      stack_sel_i,
  input  wire logic signed [dss_pkg::WordW-1:0] value_i,
  // result channel
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic signed [dss_pkg::WordW-1:0] data_o,
  output logic      [1:0]                status_o,
  output logic                           lower_empty_o,
  output logic                           upper_empty_o,
  output logic                           store_full_o
);

  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW  = $clog2(DEPTH + 1);

  logic [CntW-1:0] lower_cnt_q, lower_cnt_d;
  logic [CntW-1:0] upper_cnt_q, upper_cnt_d;
  logic            busy_q;
  logic            read_q, read_d;
  logic            under_q;
  logic [1:0]      status_q, status_d;
  logic            lower_empty_q, upper_empty_q, full_q;

  logic            in_beat;
  logic            out_beat;
  logic            full_now;
  logic            full_next;
  logic            mem_we;
  logic            mem_re;
  logic [AddrW-1:0] mem_addr;
  logic [dss_pkg::WordW-1:0] mem_rdata;
  logic [CntW-1:0] sel_cnt;
  logic [CntW-1:0] lower_top;
  logic [CntW-1:0] upper_top;
  logic [CntW-1:0] upper_push;

  // handshake: a new beat may enter as the pending result leaves
  assign out_beat   = busy_q & out_ready_i;
  assign in_ready_o = ~busy_q | out_ready_i;
  assign in_beat    = in_valid_i & in_ready_o;

  // fill state before and after the step
  assign full_now  = ({1'b0, lower_cnt_q} + {1'b0, upper_cnt_q}) >= (CntW+1)'(DEPTH);
  assign full_next = ({1'b0, lower_cnt_d} + {1'b0, upper_cnt_d}) >= (CntW+1)'(DEPTH);

  // entry positions of the two stacks
  assign sel_cnt    = stack_sel_i ? upper_cnt_q : lower_cnt_q;
  assign lower_top  = lower_cnt_q - CntW'(1);
  assign upper_top  = CntW'(DEPTH) - upper_cnt_q;
  assign upper_push = CntW'(DEPTH - 1) - upper_cnt_q;

  // decode the operation against the current counts
  always_comb begin
    lower_cnt_d = lower_cnt_q;
    upper_cnt_d = upper_cnt_q;
    status_d    = dss_pkg::ST_OK;
    read_d      = 1'b0;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_addr    = '0;
    unique case (cmd_i)
      dss_pkg::CMD_PUSH: begin
        if (full_now) begin
          status_d = dss_pkg::ST_OVERFLOW;
        end else if (!stack_sel_i) begin
          mem_we      = in_beat;
          mem_addr    = lower_cnt_q[AddrW-1:0];
          lower_cnt_d = lower_cnt_q + CntW'(1);
        end else begin
          mem_we      = in_beat;
          mem_addr    = upper_push[AddrW-1:0];
          upper_cnt_d = upper_cnt_q + CntW'(1);
        end
      end
      dss_pkg::CMD_POP, dss_pkg::CMD_PEEK: begin
        if (sel_cnt == '0) begin
          status_d = dss_pkg::ST_UNDERFLOW;
        end else begin
          read_d   = 1'b1;
          mem_re   = in_beat;
          mem_addr = stack_sel_i ? upper_top[AddrW-1:0] : lower_top[AddrW-1:0];
          if (cmd_i == dss_pkg::CMD_POP) begin
            if (stack_sel_i) begin
              upper_cnt_d = upper_cnt_q - CntW'(1);
            end else begin
              lower_cnt_d = lower_cnt_q - CntW'(1);
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  // control state: counts and pending result flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lower_cnt_q <= '0;
      upper_cnt_q <= '0;
      busy_q      <= 1'b0;
    end else begin
      if (in_beat) begin
        lower_cnt_q <= lower_cnt_d;
        upper_cnt_q <= upper_cnt_d;
        busy_q      <= 1'b1;
      end else if (out_beat) begin
        busy_q      <= 1'b0;
      end
    end
  end

  // result register, loaded with each input beat
  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      read_q        <= read_d;
      under_q       <= (status_d == dss_pkg::ST_UNDERFLOW);
      status_q      <= status_d;
      lower_empty_q <= (lower_cnt_d == '0);
      upper_empty_q <= (upper_cnt_d == '0);
      full_q        <= full_next;
    end
  end

  // shared word store
  dss_store #(
    .Depth (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .re_i    (mem_re),
    .addr_i  (mem_addr),
    .wdata_i (value_i),
    .rdata_o (mem_rdata)
  );

  // result beat
  assign out_valid_o   = busy_q;
  assign data_o        = under_q ? dss_pkg::IntMin : (read_q ? mem_rdata : '0);
  assign status_o      = status_q;
  assign lower_empty_o = lower_empty_q;
  assign upper_empty_o = upper_empty_q;
  assign store_full_o  = full_q;

endmodule
`default_nettype wire
